/* hw/rtl/pts_pkg.sv */
// Shared types and codes of the priority task scheduler.
// Used by pts_ctrl and priority_task_scheduler; depends on nothing.
package pts_pkg;

  localparam int unsigned PidW    = 6;
  localparam int unsigned LevelW  = 3;
  localparam int unsigned FuncW   = 3;
  localparam int unsigned StatusW = 2;
  localparam int unsigned SliceW  = 8;
  localparam int unsigned TimeW   = 64;
  localparam int unsigned LiveW   = 6;

  localparam logic [SliceW-1:0] SliceReset = 8'd10;
  localparam logic [PidW-1:0]   NextIdReset = 6'd2;

  // Event codes.
  localparam logic [FuncW-1:0] FnTick    = 3'd0;
  localparam logic [FuncW-1:0] FnYield   = 3'd1;
  localparam logic [FuncW-1:0] FnCreate  = 3'd2;
  localparam logic [FuncW-1:0] FnDestroy = 3'd3;
  localparam logic [FuncW-1:0] FnExit    = 3'd4;

  // Result status codes.
  localparam logic [StatusW-1:0] StOk       = 2'd0;
  localparam logic [StatusW-1:0] StPoolFull = 2'd1;
  localparam logic [StatusW-1:0] StNotFound = 2'd2;

  // Register index of slice_ticks.
  localparam int unsigned RegSliceTicks = 0;

  typedef struct packed {
    logic [PidW-1:0]   target_pid;
    logic [LevelW-1:0] level;
    logic [TimeW-1:0]  now_ticks;
    logic [FuncW-1:0]  func;
  } pts_item_t;

  typedef struct packed {
    logic [TimeW-1:0]   run_total;
    logic [SliceW-1:0]  slice_left;
    logic [LiveW-1:0]   live_tasks;
    logic [PidW-1:0]    created_pid;
    logic               switched;
    logic [PidW-1:0]    running_pid;
    logic [StatusW-1:0] status;
  } pts_res_t;

  // Per-slot scheduling word.
  typedef struct packed {
    logic              queued;
    logic [LevelW-1:0] level;
    logic [PidW-1:0]   pid;
  } pts_meta_t;

  // Per-slot accounting word.
  typedef struct packed {
    logic [TimeW-1:0] runtime;
    logic [TimeW-1:0] last_run;
  } pts_time_t;

endpackage

/* hw/rtl/priority_task_scheduler.sv */
// Fixed-priority preemptive task scheduler, top level.
// Event stream in, one result word per event out, slice register on APB.
// Depends on pts_pkg and pts_ctrl.
//
// Usage: each event word on s_axis carries func, now_ticks, level and
// target_pid; every event gives exactly one result word on m_axis. The
// slice_ticks register sits at byte address 0 of the APB port.
// Yield, destroy and exit, and a tick that ends a slice, walk the slot table
// in memory, one slot per cycle from the newest used slot down. A task
// switch then writes back the outgoing slot and loads the incoming one.
// One event is in work at a time. After reset the block writes the idle
// task into slot 0 before it accepts an event. The result sits in an output
// register; while the receiver stalls, the next event is still taken and
// worked on, and its result waits until the register frees up.
module priority_task_scheduler
  import pts_pkg::*;
#(
  parameter int unsigned POOL_SIZE = 32,
  parameter int unsigned LEVELS    = 5
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [2:0] func, [66:3] now_ticks, [69:67] level, [75:70] target_pid
  input  logic [79:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [7:2] running_pid, [8] switched, [14:9] created_pid,
  // [20:15] live_tasks, [28:21] slice_left, [92:29] run_total
  output logic [95:0] m_axis_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [SliceW-1:0] slice_q;
  logic              res_valid, res_ready;
  pts_res_t          res;
  pts_item_t         item;
  logic              out_valid_q;
  pts_res_t          out_q;

  assign pready = 1'b1;
  assign prdata = (paddr == 3'(4 * RegSliceTicks)) ? {24'b0, slice_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slice_q <= SliceReset;
    end else if (psel && penable && pwrite && pready
                 && (paddr == 3'(4 * RegSliceTicks))) begin
      slice_q <= pwdata[SliceW-1:0];
    end
  end

  assign item = pts_item_t'(s_axis_tdata[$bits(pts_item_t)-1:0]);

  pts_ctrl #(.POOL_SIZE(POOL_SIZE), .LEVELS(LEVELS)) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .slice_ticks_i (slice_q),
    .item_valid_i  (s_axis_tvalid),
    .item_ready_o  (s_axis_tready),
    .item_i        (item),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b0, out_q};

endmodule

/* hw/rtl/pts_slot_ram.sv */
// Simple dual-port synchronous RAM with registered read.
// Holds one word per task slot; no dependencies.
module pts_slot_ram #(
  parameter int unsigned Width = 10,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

/* hw/rtl/pts_ctrl.sv */
// Scheduler sequencer: event decode, slot scans, context switch and
// accounting. Depends on pts_pkg and two pts_slot_ram instances.
module pts_ctrl
  import pts_pkg::*;
#(
  parameter int unsigned POOL_SIZE = 32,
  parameter int unsigned LEVELS    = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [SliceW-1:0] slice_ticks_i,
  input  logic              item_valid_i,
  output logic              item_ready_o,
  input  pts_item_t         item_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output pts_res_t          res_o
);

  localparam int unsigned SW = $clog2(POOL_SIZE);
  localparam int unsigned CW = $clog2(POOL_SIZE + 1);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_TICK_SUB, S_TICK_ADD, S_CREATE, S_SCAN,
    S_SW_WR, S_SW_LD, S_DONE
  } state_e;

  state_e state_q;

  logic [FuncW-1:0]   func_q;
  logic [TimeW-1:0]   now_q;
  logic [LevelW-1:0]  lvl_q;
  logic [PidW-1:0]    tgt_q;
  logic [SW-1:0]      cur_slot_q;
  logic [PidW-1:0]    cur_pid_q;
  logic [SliceW-1:0]  cur_rem_q;
  logic [TimeW-1:0]   cur_run_q;
  logic [TimeW-1:0]   cur_last_q;
  logic [TimeW-1:0]   delta_q;
  logic [CW-1:0]      slots_used_q;
  logic [PidW-1:0]    next_id_q;
  logic [CW-1:0]      qcount_q;
  logic [SW-1:0]      addr_q;
  logic               issue_q;
  logic               rvld_q;
  logic [SW-1:0]      rslot_q;
  logic               found_q;
  logic [SW-1:0]      best_slot_q;
  logic [LevelW-1:0]  best_lv_q;
  logic [PidW-1:0]    best_pid_q;
  logic [StatusW-1:0] status_q;
  logic               switched_q;
  logic [PidW-1:0]    created_q;

  pts_meta_t          meta_wdata, meta_rdata;
  pts_time_t          time_wdata, time_rdata;
  logic               meta_we, time_we;
  logic [SW-1:0]      meta_waddr, time_waddr;

  logic               is_resched, full, scan_done, take;
  logic [PidW-1:0]    pid_key;
  logic [LevelW-1:0]  lvl_sat;
  logic [SliceW-1:0]  rem_next;

  assign is_resched = (func_q == FnTick) || (func_q == FnYield);
  assign full       = (slots_used_q == CW'(POOL_SIZE));
  assign scan_done  = (state_q == S_SCAN) && !issue_q && !rvld_q;
  assign pid_key    = (func_q == FnDestroy) ? tgt_q : cur_pid_q;
  assign lvl_sat    = ({1'b0, lvl_q} >= 4'(LEVELS)) ? LevelW'(LEVELS - 1) : lvl_q;
  assign rem_next   = (cur_rem_q == '0) ? '0 : cur_rem_q - 1'b1;

  // Reschedule keeps the first slot seen at a strictly higher level while
  // scanning downward, which yields the newest slot at the top level.
  // Destroy and exit keep the lowest level in the same way, among pid matches.
  always_comb begin
    take = 1'b0;
    if (rvld_q && meta_rdata.queued) begin
      if (is_resched) begin
        take = !found_q || (meta_rdata.level > best_lv_q);
      end else begin
        take = (meta_rdata.pid == pid_key) && (!found_q || (meta_rdata.level < best_lv_q));
      end
    end
  end

  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = best_slot_q;
    meta_wdata = '{queued: 1'b0, level: best_lv_q, pid: best_pid_q};
    time_we    = 1'b0;
    time_waddr = cur_slot_q;
    time_wdata = '{runtime: cur_run_q, last_run: cur_last_q};
    case (state_q)
      S_INIT: begin
        meta_we    = 1'b1;
        meta_waddr = '0;
        meta_wdata = '{queued: 1'b1, level: '0, pid: '0};
      end
      S_CREATE: begin
        meta_we    = !full;
        meta_waddr = slots_used_q[SW-1:0];
        meta_wdata = '{queued: 1'b1, level: lvl_sat, pid: next_id_q};
        time_we    = !full;
        time_waddr = slots_used_q[SW-1:0];
        time_wdata = '{runtime: '0, last_run: now_q};
      end
      S_SCAN: begin
        meta_we = scan_done && !is_resched && found_q;
      end
      S_SW_WR: begin
        time_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  pts_slot_ram #(.Width($bits(pts_meta_t)), .Depth(POOL_SIZE)) u_meta_ram (
    .clk_i   (clk_i),
    .we_i    (meta_we),
    .waddr_i (meta_waddr),
    .wdata_i (meta_wdata),
    .raddr_i (addr_q),
    .rdata_o (meta_rdata)
  );

  pts_slot_ram #(.Width($bits(pts_time_t)), .Depth(POOL_SIZE)) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (time_we),
    .waddr_i (time_waddr),
    .wdata_i (time_wdata),
    .raddr_i (best_slot_q),
    .rdata_o (time_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_INIT;
      func_q       <= FnTick;
      now_q        <= '0;
      lvl_q        <= '0;
      tgt_q        <= '0;
      cur_slot_q   <= '0;
      cur_pid_q    <= '0;
      cur_rem_q    <= SliceReset;
      cur_run_q    <= '0;
      cur_last_q   <= '0;
      delta_q      <= '0;
      slots_used_q <= CW'(1);
      next_id_q    <= NextIdReset;
      qcount_q     <= CW'(1);
      addr_q       <= '0;
      issue_q      <= 1'b0;
      rvld_q       <= 1'b0;
      rslot_q      <= '0;
      found_q      <= 1'b0;
      best_slot_q  <= '0;
      best_lv_q    <= '0;
      best_pid_q   <= '0;
      status_q     <= StOk;
      switched_q   <= 1'b0;
      created_q    <= '0;
    end else begin
      case (state_q)
        S_INIT: begin
          state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (item_valid_i) begin
            func_q     <= item_i.func;
            now_q      <= item_i.now_ticks;
            lvl_q      <= item_i.level;
            tgt_q      <= item_i.target_pid;
            status_q   <= StOk;
            switched_q <= 1'b0;
            created_q  <= '0;
            found_q    <= 1'b0;
            addr_q     <= SW'(slots_used_q - 1'b1);
            issue_q    <= 1'b1;
            rvld_q     <= 1'b0;
            case (item_i.func)
              FnTick:    state_q <= S_TICK_SUB;
              FnYield:   state_q <= S_SCAN;
              FnCreate:  state_q <= S_CREATE;
              FnDestroy: state_q <= S_SCAN;
              FnExit:    state_q <= S_SCAN;
              default:   state_q <= S_DONE;
            endcase
          end
        end
        S_TICK_SUB: begin
          delta_q <= now_q - cur_last_q;
          state_q <= S_TICK_ADD;
        end
        S_TICK_ADD: begin
          cur_run_q  <= cur_run_q + delta_q;
          cur_last_q <= now_q;
          cur_rem_q  <= rem_next;
          state_q    <= (rem_next == '0) ? S_SCAN : S_DONE;
        end
        S_CREATE: begin
          if (full) begin
            status_q <= StPoolFull;
          end else begin
            created_q    <= next_id_q;
            next_id_q    <= next_id_q + 1'b1;
            slots_used_q <= slots_used_q + 1'b1;
            qcount_q     <= qcount_q + 1'b1;
          end
          state_q <= S_DONE;
        end
        S_SCAN: begin
          rvld_q  <= issue_q;
          rslot_q <= addr_q;
          if (issue_q) begin
            if (addr_q == '0) begin
              issue_q <= 1'b0;
            end else begin
              addr_q <= addr_q - 1'b1;
            end
          end
          if (take) begin
            found_q     <= 1'b1;
            best_slot_q <= rslot_q;
            best_lv_q   <= meta_rdata.level;
            best_pid_q  <= meta_rdata.pid;
          end
          if (scan_done) begin
            if (is_resched) begin
              if (found_q && (best_slot_q != cur_slot_q)) begin
                switched_q <= 1'b1;
                state_q    <= S_SW_WR;
              end else begin
                state_q <= S_DONE;
              end
            end else begin
              if (found_q) begin
                qcount_q <= qcount_q - 1'b1;
              end else begin
                status_q <= StNotFound;
              end
              state_q <= S_DONE;
            end
          end
        end
        S_SW_WR: begin
          // The outgoing slot is written while the incoming slot is read.
          state_q <= S_SW_LD;
        end
        S_SW_LD: begin
          cur_slot_q <= best_slot_q;
          cur_pid_q  <= best_pid_q;
          cur_rem_q  <= slice_ticks_i;
          cur_run_q  <= time_rdata.runtime;
          cur_last_q <= time_rdata.last_run;
          state_q    <= S_DONE;
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign item_ready_o = (state_q == S_IDLE);
  assign res_valid_o  = (state_q == S_DONE);

  always_comb begin
    res_o             = '0;
    res_o.status      = status_q;
    res_o.running_pid = cur_pid_q;
    res_o.switched    = switched_q;
    res_o.created_pid = created_q;
    res_o.live_tasks  = LiveW'(qcount_q);
    res_o.slice_left  = cur_rem_q;
    res_o.run_total   = cur_run_q;
  end

  a_qcount_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    qcount_q <= slots_used_q)
    else $error("queued count exceeds used slots");

  a_cur_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(cur_slot_q) < slots_used_q)
    else $error("current slot beyond used slots");

  a_switch_new_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SW_LD |-> found_q && (best_slot_q != cur_slot_q) && switched_q)
    else $error("switch without a new pick");

  a_scan_no_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && issue_q) |-> !meta_we)
    else $error("slot table written during a scan");

endmodule
